### src/mctt_pkg.sv
package mctt_pkg;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [2:0] EV_FIRED    = 3'd0;
   localparam logic [2:0] EV_DONE     = 3'd1;
   localparam logic [2:0] EV_ADDED    = 3'd2;
   localparam logic [2:0] EV_FULL     = 3'd3;
   localparam logic [2:0] EV_REMOVED  = 3'd4;
   localparam logic [2:0] EV_NOTFOUND = 3'd5;

   // memory port strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mctt_mem_ctl_type;

endpackage

### src/multi_channel_software_timer_table_top.sv
// Table of NUM_TIMERS periodic or one-shot timers. An add takes the lowest free slot
// and answers with added (preceded by fired when fire_now is set) or table full; a
// remove answers removed or not found. A tick walks every slot in order through the
// single timer memory: an inactive slot is skipped, an active slot is read and checked,
// a slot that fires gives one fired item, and a repeating slot that fires with a nonzero
// interval first has its elapsed time folded by the bit-serial remainder unit; then
// one done item follows. One item is worked on at a time.
module multi_channel_software_timer_table_top import mctt_pkg::*; #(
   parameter int NUM_TIMERS = 16,
   parameter int TIME_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_delta,
   input  logic [31:0] req_period,
   input  logic        req_repeat_req,
   input  logic        req_fire_now,
   input  logic [3:0]  req_slot,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_kind,
   output logic [3:0]  rsp_handle,
   output logic        rsp_last
);

   localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CW = $clog2(NUM_TIMERS + 1);
   localparam int XW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
   localparam int TW = TIME_WIDTH;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_CALC, S_DSTART, S_DIV, S_TFIRE, S_ADDF, S_RESP
   } state_type;

   state_type               state_ff;
   logic [NUM_TIMERS-1:0]   active_ff;
   logic [CW-1:0]           idx_ff;
   logic [TW-1:0]           delta_ff;
   logic [TW-1:0]           e_ff;
   logic [TW-1:0]           iv_ff;
   logic                    rep_ff;
   logic [SW-1:0]           add_idx_ff;
   logic [2:0]              pend_kind_ff;
   logic [3:0]              pend_handle_ff;
   logic                    rsp_valid_ff;
   logic [2:0]              rsp_kind_ff;
   logic [3:0]              rsp_handle_ff;
   logic                    rsp_last_ff;

   logic                    accept;
   logic                    out_free;
   logic                    rsp_load;
   logic [TW-1:0]           delta_sat;
   logic [TW-1:0]           period_sat;
   logic [XW-1:0]           tmax_x;
   logic                    free_found;
   logic [SW-1:0]           free_idx;
   logic [6:0]              slot_x;
   logic                    rm_hit;
   logic [SW-1:0]           idx;
   logic                    idx_end;

   // memory side
   mctt_mem_ctl_type        mem_ctl;
   logic [SW-1:0]           mem_waddr;
   logic [2*TW:0]           mem_wdata;
   logic [2*TW:0]           mem_rdata;
   logic                    m_rep;
   logic [TW-1:0]           m_iv;
   logic [TW-1:0]           m_e;
   logic [TW:0]             sum;
   logic [TW-1:0]           esum;
   logic                    fire;
   logic                    fold;

   // remainder unit
   logic                    div_start;
   logic                    div_busy;
   logic                    div_done;
   logic [TW-1:0]           div_rem;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign idx      = idx_ff[SW-1:0];
   assign idx_end  = (idx_ff == CW'(NUM_TIMERS));

   // an output item is loaded in the emitting states once the register is free
   assign rsp_load = out_free && (state_ff inside {S_TFIRE, S_ADDF, S_RESP});

   // input times saturate to the time width
   assign tmax_x     = XW'({TW{1'b1}});
   assign delta_sat  = (XW'(req_delta) > tmax_x) ? {TW{1'b1}} : TW'(req_delta);
   assign period_sat = (XW'(req_period) > tmax_x) ? {TW{1'b1}} : TW'(req_period);

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SW'(i);
         end
      end
   end

   // remove lookup, slots past the table count as not found
   assign slot_x = 7'(req_slot);
   assign rm_hit = (slot_x < 7'(NUM_TIMERS)) && active_ff[slot_x[SW-1:0]];

   // entry read back in the cycle after the scan issues it
   assign m_rep = mem_rdata[2*TW];
   assign m_iv  = mem_rdata[2*TW-1:TW];
   assign m_e   = mem_rdata[TW-1:0];
   assign sum   = {1'b0, m_e} + {1'b0, delta_ff};
   assign esum  = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
   assign fire  = esum > m_iv;
   assign fold  = fire && m_rep && (m_iv != '0);

   always_comb begin
      mem_ctl   = '0;
      mem_waddr = idx;
      mem_wdata = {m_rep, m_iv, esum};
      div_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_opcode == OP_ADD && free_found) begin
               mem_ctl.wr_en = 1'b1;
               mem_waddr     = free_idx;
               mem_wdata     = {req_repeat_req, period_sat, {TW{1'b0}}};
            end
         end
         S_SCAN: begin
            mem_ctl.rd_en = !idx_end && active_ff[idx];
         end
         S_CALC: begin
            // folding slots are written once the remainder is back
            mem_ctl.wr_en = !fold;
            if (fire && m_rep) begin
               mem_wdata = {m_rep, m_iv, {TW{1'b0}}};
            end
         end
         S_DSTART: begin
            div_start = 1'b1;
         end
         S_DIV: begin
            mem_ctl.wr_en = div_done;
            mem_wdata     = {rep_ff, iv_ff, div_rem + 1'b1};
         end
         default: begin
         end
      endcase
   end

   mctt_mem #(
      .NUM_TIMERS (NUM_TIMERS),
      .TIME_WIDTH (TIME_WIDTH),
      .SW         (SW)
   ) u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (idx),
      .rd_data (mem_rdata)
   );

   // (elapsed - 1) mod interval
   mctt_mod #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (e_ff - 1'b1),
      .divisor   (iv_ff),
      .busy      (div_busy),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  case (req_opcode)
                     OP_TICK: begin
                        delta_ff <= delta_sat;
                        idx_ff   <= '0;
                        state_ff <= S_SCAN;
                     end
                     OP_ADD: begin
                        if (free_found) begin
                           active_ff[free_idx] <= 1'b1;
                           add_idx_ff          <= free_idx;
                           pend_kind_ff        <= EV_ADDED;
                           pend_handle_ff      <= 4'(free_idx);
                           state_ff            <= req_fire_now ? S_ADDF : S_RESP;
                        end else begin
                           pend_kind_ff   <= EV_FULL;
                           pend_handle_ff <= 4'd0;
                           state_ff       <= S_RESP;
                        end
                     end
                     OP_REMOVE: begin
                        pend_handle_ff <= req_slot;
                        if (rm_hit) begin
                           active_ff[slot_x[SW-1:0]] <= 1'b0;
                           pend_kind_ff              <= EV_REMOVED;
                        end else begin
                           pend_kind_ff <= EV_NOTFOUND;
                        end
                        state_ff <= S_RESP;
                     end
                     default: begin
                        // unused opcode, dropped
                     end
                  endcase
               end
            end
            S_SCAN: begin
               if (idx_end) begin
                  pend_kind_ff   <= EV_DONE;
                  pend_handle_ff <= 4'd0;
                  state_ff       <= S_RESP;
               end else if (active_ff[idx]) begin
                  state_ff <= S_CALC;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_CALC: begin
               e_ff   <= esum;
               iv_ff  <= m_iv;
               rep_ff <= m_rep;
               if (!fire) begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_SCAN;
               end else if (fold) begin
                  state_ff <= S_DSTART;
               end else begin
                  if (!m_rep) begin
                     active_ff[idx] <= 1'b0;
                  end
                  state_ff <= S_TFIRE;
               end
            end
            S_DSTART: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_TFIRE;
               end
            end
            S_TFIRE: begin
               if (out_free) begin
                  rsp_kind_ff   <= EV_FIRED;
                  rsp_handle_ff <= 4'(idx);
                  rsp_last_ff   <= 1'b0;
                  idx_ff        <= idx_ff + 1'b1;
                  state_ff      <= S_SCAN;
               end
            end
            S_ADDF: begin
               if (out_free) begin
                  rsp_kind_ff   <= EV_FIRED;
                  rsp_handle_ff <= 4'(add_idx_ff);
                  rsp_last_ff   <= 1'b0;
                  state_ff      <= S_RESP;
               end
            end
            S_RESP: begin
               if (out_free) begin
                  rsp_kind_ff   <= pend_kind_ff;
                  rsp_handle_ff <= pend_handle_ff;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = rsp_kind_ff;
   assign rsp_handle     = rsp_handle_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // the remainder unit only reports while the scan waits on it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("remainder done outside fold wait");

   // no new item while a fold is still running
   a_idle_not_busy: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_busy)
      else $error("ready while remainder unit busy");

   // only fire items precede the final item of a request
   a_not_last_is_fire: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_event_kind == EV_FIRED)
      else $error("non-final item that is not a fire");

   // a tick, or an add to a full table, closes with handle zero as the final item
   a_done_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == EV_DONE || rsp_event_kind == EV_FULL)
         |-> rsp_handle == 4'd0 && rsp_last)
      else $error("done or full item malformed");
`endif

endmodule

### src/mctt_mem.sv
module mctt_mem import mctt_pkg::*; #(
   parameter int NUM_TIMERS = 16,
   parameter int TIME_WIDTH = 32,
   parameter int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
   input  logic                    clock,
   input  mctt_mem_ctl_type        ctl,
   input  logic [SW-1:0]           wr_addr,
   input  logic [2*TIME_WIDTH:0]   wr_data,
   input  logic [SW-1:0]           rd_addr,
   output logic [2*TIME_WIDTH:0]   rd_data
);

   // entry: {repeat, interval, elapsed}
   logic [2*TIME_WIDTH:0] mem [NUM_TIMERS];
   logic [2*TIME_WIDTH:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/mctt_mod.sv
module mctt_mod #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [TIME_WIDTH-1:0] dividend,
   input  logic [TIME_WIDTH-1:0] divisor,
   output logic                  busy,
   output logic                  done,
   output logic [TIME_WIDTH-1:0] remainder
);

   localparam int CW = $clog2(TIME_WIDTH + 1);

   logic [CW-1:0]         cnt_ff;
   logic                  run_ff;
   logic                  done_ff;
   logic [TIME_WIDTH-1:0] rem_ff;
   logic [TIME_WIDTH-1:0] sh_ff;
   logic [TIME_WIDTH-1:0] div_ff;
   logic [TIME_WIDTH:0]   trial;
   logic [TIME_WIDTH:0]   rem_in;

   // restoring remainder, one dividend bit per cycle
   always_comb begin
      trial = {rem_ff, sh_ff[TIME_WIDTH-1]};
      if (trial >= {1'b0, div_ff}) begin
         rem_in = trial - {1'b0, div_ff};
      end else begin
         rem_in = trial;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && run_ff && (cnt_ff == CW'(1));
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CW'(TIME_WIDTH);
            rem_ff <= '0;
            sh_ff  <= dividend;
            div_ff <= divisor;
         end else if (run_ff) begin
            rem_ff <= rem_in[TIME_WIDTH-1:0];
            sh_ff  <= sh_ff << 1;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   assign busy      = run_ff;
   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
